// ===== rtl/irt_pkg.sv =====
package irt_pkg;

  // Fixed field widths of the request and response words
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_FULL     = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_HELD     = 3'd4,
    ST_EMPTIED  = 3'd5,
    ST_FREED    = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_PUT_RD,
    S_COMMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // zero one count entry, advance sweep
    logic load;    // capture request word, restart scan
    logic scan;    // issue next scan read, evaluate returned entry
    logic commit;  // update table and load response register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/irt_req_if.sv =====
interface irt_req_if;
  import irt_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [NUM_W-1:0]  inode_number;
  logic [SLOT_W-1:0] slot;
  logic              links_gone;

  modport source (
    output valid, op, inode_number, slot, links_gone,
    input  ready
  );

  modport sink (
    input  valid, op, inode_number, slot, links_gone,
    output ready
  );
endinterface

// ===== rtl/irt_rsp_if.sv =====
interface irt_rsp_if;
  import irt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic [NUM_W-1:0]    number_out;

  modport source (
    output valid, status, slot_out, number_out,
    input  ready
  );

  modport sink (
    input  valid, status, slot_out, number_out,
    output ready
  );
endinterface

// ===== rtl/irt_ctrl.sv =====
module irt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  input  irt_pkg::sts_t sts_i,
  output irt_pkg::cmd_t cmd_o,
  output logic          in_ready_o
);
  import irt_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (op_e'(in_op_i) == OP_PUT) ? S_PUT_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = S_COMMIT;
      end
      S_PUT_RD: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/irt_dpath.sv =====
module irt_dpath #(
  parameter int unsigned TABLE_SLOTS = 64,
  parameter int unsigned COUNT_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  irt_pkg::cmd_t                 cmd_i,
  input  logic                          op_i,
  input  logic [irt_pkg::NUM_W-1:0]     inode_number_i,
  input  logic [irt_pkg::SLOT_W-1:0]    slot_i,
  input  logic                          links_gone_i,
  input  logic                          out_ready_i,
  output irt_pkg::sts_t                 sts_o,
  output logic                          out_valid_o,
  output logic [irt_pkg::STATUS_W-1:0]  status_o,
  output logic [irt_pkg::SLOT_W-1:0]    slot_out_o,
  output logic [irt_pkg::NUM_W-1:0]     number_out_o
);
  import irt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Table storage
  logic [NUM_W-1:0]      num_mem [TABLE_SLOTS];
  logic [COUNT_BITS-1:0] cnt_mem [TABLE_SLOTS];

  // Captured request word
  logic              op_q;
  logic [NUM_W-1:0]  num_q;
  logic [SLOT_W-1:0] slot_q;
  logic              gone_q;

  // Sweep and scan control
  logic [IDX_W-1:0] clr_idx_q;
  logic [IDX_W-1:0] scan_addr_q;
  logic [IDX_W-1:0] data_idx_q;
  logic             rd_vld_q;

  // Registered read data
  logic [NUM_W-1:0]      rd_num_q;
  logic [COUNT_BITS-1:0] rd_cnt_q;
  logic [IDX_W-1:0]      rd_addr;

  // Scan findings
  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  logic                  free_q;
  logic [IDX_W-1:0]      free_idx_q;

  // Response register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [NUM_W-1:0]    out_num_q;

  // Commit results
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  num_we;
  status_e               res_status;
  logic [SLOT_W-1:0]     res_slot;
  logic [NUM_W-1:0]      res_num;

  logic                  slot_in_range;
  logic [IDX_W-1:0]      slot_idx;
  logic [COUNT_BITS-1:0] dec_cnt;
  logic                  entry_match;

  assign slot_idx      = IDX_W'(slot_q);
  assign slot_in_range = 32'(slot_q) < 32'(TABLE_SLOTS);
  assign dec_cnt       = rd_cnt_q - COUNT_ONE;
  assign entry_match   = (rd_cnt_q != '0) && (rd_num_q == num_q);

  // A put reads its own slot, a get walks the scan address
  assign rd_addr = (op_e'(op_q) == OP_PUT) ? slot_idx : scan_addr_q;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      num_q  <= inode_number_i;
      slot_q <= slot_i;
      gone_q <= links_gone_i;
    end
  end

  // Sweep counter for the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear) begin
      clr_idx_q <= clr_idx_q + IDX_W'(1);
    end
  end

  // Scan address and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
    end else if (cmd_i.load) begin
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.scan) begin
        scan_addr_q <= scan_addr_q + IDX_W'(1);
        if (rd_vld_q && !hit_q) begin
          if (entry_match) hit_q <= 1'b1;
          else if (!free_q && rd_cnt_q == '0) free_q <= 1'b1;
        end
      end
    end
  end

  // Findings payload
  always_ff @(posedge clk_i) begin
    data_idx_q <= scan_addr_q;
    if (cmd_i.scan && rd_vld_q && !hit_q) begin
      if (entry_match) begin
        hit_idx_q <= data_idx_q;
        hit_cnt_q <= rd_cnt_q;
      end else if (!free_q && rd_cnt_q == '0) begin
        free_idx_q <= data_idx_q;
      end
    end
  end

  // Commit decision and table update
  always_comb begin
    cnt_we     = 1'b0;
    cnt_waddr  = clr_idx_q;
    cnt_wdata  = '0;
    num_we     = 1'b0;
    res_status = ST_EMPTIED;
    res_slot   = slot_q;
    res_num    = '0;
    if (cmd_i.clear) begin
      cnt_we = 1'b1;
    end else if (cmd_i.commit) begin
      if (op_e'(op_q) == OP_GET) begin
        res_num = num_q;
        if (hit_q) begin
          res_slot = SLOT_W'(hit_idx_q);
          if (hit_cnt_q == COUNT_MAX) begin
            res_status = ST_OVERFLOW;
          end else begin
            res_status = ST_HIT;
            cnt_we     = 1'b1;
            cnt_waddr  = hit_idx_q;
            cnt_wdata  = hit_cnt_q + COUNT_ONE;
          end
        end else if (free_q) begin
          res_status = ST_MISS;
          res_slot   = SLOT_W'(free_idx_q);
          cnt_we     = 1'b1;
          cnt_waddr  = free_idx_q;
          cnt_wdata  = COUNT_ONE;
          num_we     = 1'b1;
        end else begin
          res_status = ST_FULL;
          res_slot   = '0;
        end
      end else if (slot_in_range && rd_cnt_q != '0) begin
        res_num   = rd_num_q;
        cnt_we    = 1'b1;
        cnt_waddr = slot_idx;
        cnt_wdata = dec_cnt;
        if (dec_cnt != '0) res_status = ST_HELD;
        else if (gone_q)   res_status = ST_FREED;
        else               res_status = ST_EMPTIED;
      end
    end
  end

  // Count memory
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    rd_cnt_q <= cnt_mem[rd_addr];
  end

  // Inode number memory
  always_ff @(posedge clk_i) begin
    if (num_we) num_mem[free_idx_q] <= num_q;
    rd_num_q <= num_mem[rd_addr];
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot;
      out_num_q    <= res_num;
    end
  end

  assign sts_o.clear_done = clr_idx_q == LAST_IDX;
  assign sts_o.scan_done  = rd_vld_q && (entry_match || data_idx_q == LAST_IDX);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign slot_out_o   = out_slot_q;
  assign number_out_o = out_num_q;

endmodule

// ===== rtl/inode_reference_table.sv =====
// Reference-counted inode slot table.
// req_i carries one request word: op selects get (look up inode_number) or
// put (release slot, with links_gone telling whether the inode may be freed).
// rsp_o returns exactly one word per request: status, slot_out, number_out.
// Both channels move a word when valid and ready are high at a clock edge.
// Requests are handled one at a time; req_i.ready is high only while idle.
// A get walks the table one entry per cycle through the registered read
// port of the count and number memories and stops at the first live match;
// for a miss or a full table it walks on to the last slot. A put reads its
// slot once, then answers.
// req_i.ready rises again together with rsp_o.valid.
// After reset the block sweeps the count memory to zero, one entry a cycle;
// req_i.ready stays low during that pass. The response register holds its
// word while rsp_o.ready is low, and the block may already accept and work
// on the next request meanwhile; it waits with the table update until the
// held word has been taken.
module inode_reference_table #(
  parameter int unsigned TABLE_SLOTS = 64,
  parameter int unsigned COUNT_BITS  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  irt_req_if.sink   req_i,
  irt_rsp_if.source rsp_o
);
  import irt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  irt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_op_i    (req_i.op),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (req_i.ready)
  );

  irt_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (req_i.op),
    .inode_number_i (req_i.inode_number),
    .slot_i         (req_i.slot),
    .links_gone_i   (req_i.links_gone),
    .out_ready_i    (rsp_o.ready),
    .sts_o          (sts),
    .out_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .slot_out_o     (rsp_o.slot_out),
    .number_out_o   (rsp_o.number_out)
  );

`ifndef SYNTHESIS
  // Table update only when the response register can take the word
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !sts.out_busy)
    else $error("commit while response register busy");

  // Every commit shows a response word next cycle
  a_commit_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> rsp_o.valid)
    else $error("commit without response word");

  // One request in flight at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while busy");

  // Clearing pass never overlaps request handling
  a_clear_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !(cmd.load || cmd.scan || cmd.commit))
    else $error("clearing pass overlaps request");
`endif

endmodule

// ===== dv/irt_checker.sv =====
// Watches the request and response channels of the inode table, keeps its own
// copy of the slot table and checks every response word against it.
module irt_checker #(
  parameter int unsigned TABLE_SLOTS = 64,
  parameter int unsigned COUNT_BITS  = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  irt_req_if    req_i,
  irt_rsp_if    rsp_i,
  output int    fail_count_o,
  output int    pending_o
);
  import irt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [NUM_W-1:0]  number;
  } rsp_word_t;

  // Shadow of the slot table
  logic [NUM_W-1:0]      inode_at [TABLE_SLOTS];
  logic [COUNT_BITS-1:0] ref_cnt  [TABLE_SLOTS];

  rsp_word_t rsp_due_q [$];
  int        mismatches = 0;

  assign fail_count_o = mismatches;

  initial pending_o = 0;

  task automatic report_mismatch(input string what, input logic [NUM_W-1:0] want,
                                 input logic [NUM_W-1:0] got);
    mismatches++;
    $display("%0t ns MISMATCH %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  // Applies one request word to the shadow table, returns the response word
  function automatic rsp_word_t table_step(input logic op_bit, input logic [NUM_W-1:0] num,
                                           input logic [SLOT_W-1:0] sl, input logic gone);
    rsp_word_t w;
    int        hit_idx;
    int        free_idx;
    hit_idx  = -1;
    free_idx = -1;
    w.number = num;
    w.slot   = '0;
    w.status = ST_HIT;
    if (op_e'(op_bit) == OP_GET) begin
      // lowest live match wins, else lowest free slot
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (hit_idx < 0 && ref_cnt[i] != '0 && inode_at[i] == num) hit_idx = i;
        if (free_idx < 0 && ref_cnt[i] == '0) free_idx = i;
      end
      if (hit_idx >= 0) begin
        w.slot = hit_idx[SLOT_W-1:0];
        if (ref_cnt[hit_idx] == CNT_MAX) begin
          w.status = ST_OVERFLOW;
        end else begin
          ref_cnt[hit_idx] = ref_cnt[hit_idx] + 1'b1;
          w.status = ST_HIT;
        end
      end else if (free_idx < 0) begin
        w.status = ST_FULL;
      end else begin
        inode_at[free_idx] = num;
        ref_cnt[free_idx]  = COUNT_BITS'(1);
        w.slot   = free_idx[SLOT_W-1:0];
        w.status = ST_MISS;
      end
    end else begin
      w.slot = sl;
      // release of a free or nonexistent slot changes nothing
      if (int'(sl) >= TABLE_SLOTS || ref_cnt[sl] == '0) begin
        w.status = ST_EMPTIED;
        w.number = '0;
      end else begin
        w.number    = inode_at[sl];
        ref_cnt[sl] = ref_cnt[sl] - 1'b1;
        if (ref_cnt[sl] != '0) w.status = ST_HELD;
        else if (gone)         w.status = ST_FREED;
        else                   w.status = ST_EMPTIED;
      end
    end
    return w;
  endfunction

  // Compare responses first, then predict the request taken at this edge
  always @(posedge clk_i) begin
    rsp_word_t want;
    if (!rst_ni) begin
      rsp_due_q.delete();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        ref_cnt[i]  = '0;
        inode_at[i] = '0;
      end
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (rsp_due_q.size() == 0) begin
          report_mismatch("response word with none expected, number", '0, rsp_i.number_out);
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch("status", NUM_W'(want.status), NUM_W'(rsp_i.status));
          if (rsp_i.slot_out !== want.slot)
            report_mismatch("slot_out", NUM_W'(want.slot), NUM_W'(rsp_i.slot_out));
          if (rsp_i.number_out !== want.number)
            report_mismatch("number_out", want.number, rsp_i.number_out);
        end
      end
      if (req_i.valid && req_i.ready)
        rsp_due_q.push_back(table_step(req_i.op, req_i.inode_number, req_i.slot,
                                       req_i.links_gone));
    end
    pending_o <= rsp_due_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Stimulus and verdict for the inode reference table.
module tb_top;

  import irt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_SLOTS = 64;
  localparam int unsigned COUNT_BITS  = 8;

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic rsp_take = 1'b0;
  int   fail_count;
  int   pending;
  int   item_count = 0;
  int   stall_left = 0;
  bit   calm  = 1'b0;
  bit   quiet = 1'b0;

  irt_req_if req_if ();
  irt_rsp_if rsp_if ();

  assign rsp_if.ready = rsp_take;

  inode_reference_table #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .COUNT_BITS  (COUNT_BITS)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  irt_checker #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response side: random stall bursts on rsp_take
  always @(posedge clk) begin
    if (stall_left != 0) begin
      rsp_take   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && !quiet && !calm && $urandom_range(0, 7) == 0) begin
      rsp_take   <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      rsp_take <= 1'b1;
    end
  end

  // One request word, with an optional idle burst before it
  task automatic send_word(input op_e op, input logic [NUM_W-1:0] num,
                           input logic [SLOT_W-1:0] sl, input logic gone);
    int gap;
    gap = 0;
    if (!quiet && !calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.inode_number <= num;
    req_if.slot         <= sl;
    req_if.links_gone   <= gone;
    do @(posedge clk); while (!req_if.ready);
    item_count++;
    if (item_count % 64 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  // Unused fields carry random noise
  task automatic get_inode(input logic [NUM_W-1:0] num);
    send_word(OP_GET, num, SLOT_W'($urandom()), 1'($urandom()));
  endtask

  task automatic put_slot(input logic [SLOT_W-1:0] sl, input logic gone);
    send_word(OP_PUT, NUM_W'($urandom()), sl, gone);
  endtask

  // Hold off until every response word has come back
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [NUM_W-1:0] fill_num [70];
    logic [NUM_W-1:0] pool [12];
    logic [NUM_W-1:0] ovf_num;
    logic [NUM_W-1:0] n;
    int               w;

    req_if.valid        <= 1'b0;
    req_if.op           <= OP_GET;
    req_if.inode_number <= '0;
    req_if.slot         <= '0;
    req_if.links_gone   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, hit, held, freed, release of free slots
    get_inode(16'h0000);
    get_inode(16'hFFFF);
    get_inode(16'h0000);
    put_slot(6'd0, 1'b0);
    put_slot(6'd0, 1'b1);
    put_slot(6'd0, 1'b0);
    put_slot(6'd63, 1'b1);
    get_inode(16'hA5A5);
    get_inode(16'h5A5A);
    put_slot(6'd1, 1'b0);
    put_slot(6'd2, 1'b1);
    put_slot(6'd0, 1'b1);

    // Fill the table past full, hit a few entries, then sweep it empty
    for (int i = 0; i < 70; i++) begin
      fill_num[i] = NUM_W'($urandom());
      get_inode(fill_num[i]);
    end
    for (int i = 0; i < 8; i++) get_inode(fill_num[i * 8]);
    for (int s = 0; s < 4; s++)
      for (int i = 0; i < TABLE_SLOTS; i++) put_slot(SLOT_W'(i), 1'($urandom()));

    // Count saturation on one inode, then release it to zero
    ovf_num = NUM_W'($urandom());
    for (int i = 0; i < (1 << COUNT_BITS) + 3; i++) get_inode(ovf_num);
    for (int i = 0; i < (1 << COUNT_BITS); i++) put_slot(6'd0, 1'($urandom()));

    drain_responses();

    // Random mix, mostly over a small pool of inode numbers and low slots
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < 12; i++) pool[i] = NUM_W'($urandom());
    for (int k = 0; k < 600; k++) begin
      quiet = (k >= 450);
      if (quiet) calm = 1'b1;
      if (k == 250) drain_responses();
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 3) == 0) n = NUM_W'($urandom());
        else n = pool[$urandom_range(0, 11)];
        get_inode(n);
      end else if ($urandom_range(0, 9) < 7) begin
        put_slot(SLOT_W'($urandom_range(0, 15)), 1'($urandom()));
      end else begin
        put_slot(SLOT_W'($urandom_range(0, 63)), 1'($urandom()));
      end
    end

    // Wait out the last responses, bounded
    req_if.valid <= 1'b0;
    @(posedge clk);
    w = 0;
    while (pending != 0 && w < 5000) begin
      @(posedge clk);
      w++;
    end
    repeat (80) @(posedge clk);
    if (pending != 0) $display("%0d expected response words never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
